[src/mct_pkg.sv]
// mct_pkg: shared types and register map constants for the multi comparator timer
package mct_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // global register offsets
    localparam logic [11:0] OFF_FRC_EN = 12'h100;
    localparam logic [11:0] OFF_CNT_LO = 12'h110;
    localparam logic [11:0] OFF_CNT_HI = 12'h114;

    // comparator blocks start at page 2 (0x200), one 0x100 page each
    localparam int unsigned COMP_BASE_PAGE = 2;
    localparam int unsigned MAX_COMPARATORS = 12;
    localparam int unsigned IRQ_W = 12;

    // offsets inside a comparator page
    localparam logic [7:0] C_TGT_LO = 8'h00;
    localparam logic [7:0] C_TGT_HI = 8'h04;
    localparam logic [7:0] C_MODE   = 8'h08;
    localparam logic [7:0] C_PERIOD = 8'h0C;
    localparam logic [7:0] C_ENABLE = 8'h10;
    localparam logic [7:0] C_INTEN  = 8'h14;
    localparam logic [7:0] C_STATUS = 8'h18;

    localparam logic [8:0] PRESCALE_RESET = 9'd3;

    // counter state seen by the comparators
    typedef struct packed {
        logic        inc;
        logic [63:0] cur;
        logic [63:0] nxt;
    } mct_cnt_t;

    // item presented to a comparator
    typedef struct packed {
        logic        go;
        logic [1:0]  kind;
        logic        sel;
        logic [7:0]  off;
        logic [31:0] wdata;
    } mct_cmd_t;

    // per-comparator result
    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
    } mct_cmp_out_t;

endpackage

[src/mct_in_if.sv]
// mct_in_if: input item channel of the multi comparator timer
interface mct_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [31:0] wdata;

    modport source (output valid, output kind, output addr, output wdata, input ready);
    modport sink (input valid, input kind, input addr, input wdata, output ready);
endinterface

[src/mct_out_if.sv]
// mct_out_if: result item channel of the multi comparator timer
interface mct_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rdata;
    logic [11:0] irq_lines;

    modport source (output valid, output rdata, output irq_lines, input ready);
    modport sink (input valid, input rdata, input irq_lines, output ready);
endinterface

[src/mct_counter.sv]
// mct_counter: prescaler, 64-bit free-running counter and global registers
module mct_counter
    import mct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        go,
    input  logic [1:0]  kind,
    input  logic [11:0] addr,
    input  logic [31:0] wdata,
    output mct_cnt_t    cnt,
    output logic [31:0] rdata
);

    logic [8:0]  div_reg;
    logic [7:0]  pcount_reg;
    logic [7:0]  pcount_next;
    logic [63:0] counter_reg;
    logic        running_reg;
    logic        running_next;
    logic [7:0]  limit;
    logic        tick;

    // prescaler and increment decision
    assign limit = 8'(div_reg - 9'd1);
    assign tick  = go && (kind == KIND_TICK) && running_reg;

    always_comb
    begin
        cnt.cur     = counter_reg;
        cnt.inc     = tick && (pcount_reg >= limit);
        cnt.nxt     = cnt.inc ? counter_reg + 64'd1 : counter_reg;
        pcount_next = pcount_reg;
        if (tick)
        begin
            pcount_next = cnt.inc ? 8'd0 : pcount_reg + 8'd1;
        end
        running_next = running_reg;
        if (go && (kind == KIND_WRITE) && (addr == OFF_FRC_EN))
        begin
            running_next = wdata[0];
        end
    end

    // global register read decode
    always_comb
    begin
        rdata = 32'd0;
        if (kind == KIND_READ)
        begin
            unique case (addr)
                OFF_FRC_EN: rdata = {31'd0, running_reg};
                OFF_CNT_LO: rdata = counter_reg[31:0];
                OFF_CNT_HI: rdata = counter_reg[63:32];
                default:    rdata = 32'd0;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg     <= PRESCALE_RESET;
            pcount_reg  <= 8'd0;
            counter_reg <= 64'd0;
            running_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                div_reg <= cfg_wdata;
            end
            pcount_reg  <= pcount_next;
            counter_reg <= cnt.nxt;
            running_reg <= running_next;
        end
    end

endmodule

[src/mct_comparator.sv]
// mct_comparator: one compare timer with its registers, match and re-arm logic
module mct_comparator
    import mct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mct_cnt_t     cnt,
    input  mct_cmd_t     cmd,
    output mct_cmp_out_t res
);

    logic [31:0] period_reg;
    logic [31:0] period_next;
    logic [63:0] target_reg;
    logic [63:0] target_next;
    logic        circular_reg;
    logic        circular_next;
    logic        enabled_reg;
    logic        enabled_next;
    logic        armed_reg;
    logic        armed_next;
    logic        inten_reg;
    logic        inten_next;
    logic        status_reg;
    logic        status_next;
    logic        wr;
    logic        bit0;

    assign wr   = cmd.go && cmd.sel && (cmd.kind == KIND_WRITE);
    assign bit0 = cmd.wdata[0];

    // match on increment, then register writes
    always_comb
    begin
        period_next   = period_reg;
        target_next   = target_reg;
        circular_next = circular_reg;
        enabled_next  = enabled_reg;
        armed_next    = armed_reg;
        inten_next    = inten_reg;
        status_next   = status_reg;

        if (cnt.inc && armed_reg && (cnt.nxt == target_reg))
        begin
            status_next = 1'b1;
            if (circular_reg)
            begin
                target_next = target_reg + {32'd0, period_reg};
            end
            else
            begin
                armed_next = 1'b0;
            end
        end

        if (wr)
        begin
            unique case (cmd.off)
                C_MODE:   circular_next = bit0;
                C_PERIOD: period_next = cmd.wdata;
                C_ENABLE:
                begin
                    if (bit0 && !enabled_reg)
                    begin
                        enabled_next = 1'b1;
                        armed_next   = 1'b1;
                        target_next  = cnt.cur + {32'd0, period_reg};
                    end
                    else if (!bit0)
                    begin
                        enabled_next = 1'b0;
                        armed_next   = 1'b0;
                    end
                end
                C_INTEN:  inten_next = bit0;
                C_STATUS:
                begin
                    if (bit0)
                    begin
                        status_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // read decode and interrupt level after the item
    always_comb
    begin
        res.rdata = 32'd0;
        if (cmd.sel && (cmd.kind == KIND_READ))
        begin
            unique case (cmd.off)
                C_TGT_LO: res.rdata = target_reg[31:0];
                C_TGT_HI: res.rdata = target_reg[63:32];
                C_MODE:   res.rdata = {31'd0, circular_reg};
                C_PERIOD: res.rdata = period_reg;
                C_ENABLE: res.rdata = {31'd0, enabled_reg};
                C_INTEN:  res.rdata = {31'd0, inten_reg};
                C_STATUS: res.rdata = {31'd0, status_reg};
                default:  res.rdata = 32'd0;
            endcase
        end
        res.irq = status_next && inten_next;
    end

    // state registers, advanced only when an item is applied
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= 32'd0;
            target_reg   <= 64'd0;
            circular_reg <= 1'b0;
            enabled_reg  <= 1'b0;
            armed_reg    <= 1'b0;
            inten_reg    <= 1'b0;
            status_reg   <= 1'b0;
        end
        else if (cmd.go)
        begin
            period_reg   <= period_next;
            target_reg   <= target_next;
            circular_reg <= circular_next;
            enabled_reg  <= enabled_next;
            armed_reg    <= armed_next;
            inten_reg    <= inten_next;
            status_reg   <= status_next;
        end
    end

endmodule

[src/multi_comparator_timer.sv]
// multi_comparator_timer: top level with input register, counter, comparators and result register
//
// A 64-bit free-running counter with NUM_COMPARATORS compare timers. Each input item (a source
// clock tick, a register read or a register write) is captured in an input register, applied
// to the counter and comparator state as it moves into the result register, and its result
// (read data and the interrupt lines after the item) is held there. One item is accepted every
// cycle unless the result register stalls; each item passes through the input register and the
// result register, and a stalled result register holds the input side only when both are full.
// The user must write prescale_div through cfg_we/cfg_wdata while the block is idle; no logic checks it.
module multi_comparator_timer
    import mct_pkg::*;
#(
    parameter int unsigned NUM_COMPARATORS = 12
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,
    mct_in_if.sink     in,
    mct_out_if.source  out
);

    logic        s1_valid_reg;
    logic [1:0]  s1_kind_reg;
    logic [11:0] s1_addr_reg;
    logic [31:0] s1_wdata_reg;
    logic        out_valid_reg;
    logic [31:0] out_rdata_reg;
    logic [IRQ_W-1:0] out_irq_reg;
    logic        go;

    mct_cnt_t     cnt;
    logic [31:0]  cnt_rdata;
    mct_cmp_out_t cmp_res [NUM_COMPARATORS];
    logic [31:0]  rdata_all;
    logic [IRQ_W-1:0] irq_all;

    // handshake: the applied item moves into the result register
    assign go       = s1_valid_reg && (!out_valid_reg || out.ready);
    assign in.ready = !s1_valid_reg || go;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in.ready)
        begin
            s1_valid_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.ready && in.valid)
        begin
            s1_kind_reg  <= in.kind;
            s1_addr_reg  <= in.addr;
            s1_wdata_reg <= in.wdata;
        end
    end

    // counter and global registers
    mct_counter u_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .go        (go),
        .kind      (s1_kind_reg),
        .addr      (s1_addr_reg),
        .wdata     (s1_wdata_reg),
        .cnt       (cnt),
        .rdata     (cnt_rdata)
    );

    // comparators, one per address page
    for (genvar i = 0; i < NUM_COMPARATORS; i++)
    begin : g_cmp
        mct_cmd_t cmd;

        always_comb
        begin
            cmd.go    = go;
            cmd.kind  = s1_kind_reg;
            cmd.sel   = (s1_addr_reg[11:8] == 4'(COMP_BASE_PAGE + i));
            cmd.off   = s1_addr_reg[7:0];
            cmd.wdata = s1_wdata_reg;
        end

        mct_comparator u_cmp (
            .clk   (clk),
            .rst_n (rst_n),
            .cnt   (cnt),
            .cmd   (cmd),
            .res   (cmp_res[i])
        );
    end

    // merge read data and interrupt lines
    always_comb
    begin
        rdata_all = cnt_rdata;
        irq_all   = '0;
        for (int i = 0; i < NUM_COMPARATORS; i++)
        begin
            rdata_all  = rdata_all | cmp_res[i].rdata;
            irq_all[i] = cmp_res[i].irq;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_rdata_reg <= rdata_all;
            out_irq_reg   <= irq_all;
        end
    end

    assign out.valid     = out_valid_reg;
    assign out.rdata     = out_rdata_reg;
    assign out.irq_lines = out_irq_reg;

endmodule
